>>> rtl/core/drrp_pkg.sv
// drrp_pkg: shared types, command codes and widths for the DMA receive ring core.
// No dependencies; used by drrp_front, drrp_back and the top level.
package drrp_pkg;

    localparam int HALF_SIZE_DEF = 32;   // bytes per DMA half
    localparam int Q_DEPTH       = 2;    // depth of the op queue and the result queue

    localparam int CMD_W  = 2;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUBLISH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

    // op handed from the front to the back
    typedef struct packed {
        logic [CMD_W-1:0]  kind;
        logic [POS_W-1:0]  pos;     // write index or new end
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } op_t;

    // one result word
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              data_valid;
        logic              last;
        logic              status;
    } result_t;

endpackage

>>> rtl/core/drrp_fifo.sv
// drrp_fifo: small register FIFO used for the op queue and the result queue.
// Depends on nothing; widths come in as parameters.
module drrp_fifo #(
    parameter int DEPTH  = 2,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/drrp_front.sv
// drrp_front: accepts input words, drops the ones with no effect, queues the rest.
// Depends on drrp_pkg and drrp_fifo.
module drrp_front #(
    parameter int HALF_SIZE = drrp_pkg::HALF_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [drrp_pkg::CMD_W-1:0]  command,
    input  logic [drrp_pkg::POS_W-1:0]  write_index,
    input  logic [drrp_pkg::BYTE_W-1:0] write_byte,
    input  logic [drrp_pkg::POS_W-1:0]  new_end,
    input  logic [drrp_pkg::CNT_W-1:0]  read_count,
    output logic                        op_valid,
    output drrp_pkg::op_t               op,
    input  logic                        op_pop
);

    localparam logic [drrp_pkg::POS_W:0] RING = (drrp_pkg::POS_W + 1)'(2 * HALF_SIZE);

    drrp_pkg::op_t op_in;
    logic          keep;
    logic          q_full, q_empty;

    // out-of-ring writes/publishes and unknown commands are swallowed here
    always_comb
    begin
        op_in.kind  = command;
        op_in.pos   = (command == drrp_pkg::CMD_WRITE) ? write_index : new_end;
        op_in.data  = write_byte;
        op_in.count = read_count;
        case (command)
            drrp_pkg::CMD_WRITE:   keep = ({1'b0, write_index} < RING);
            drrp_pkg::CMD_PUBLISH: keep = ({1'b0, new_end} < RING);
            drrp_pkg::CMD_READ:    keep = 1'b1;
            default:               keep = 1'b0;
        endcase
    end

    drrp_fifo #(
        .DEPTH  (drrp_pkg::Q_DEPTH),
        .DATA_W ($bits(drrp_pkg::op_t))
    ) u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (op_in),
        .full    (q_full),
        .rd_en   (op_pop),
        .rd_data (op),
        .empty   (q_empty)
    );

    assign full     = q_full;
    assign op_valid = !q_empty;

endmodule

>>> rtl/core/drrp_back.sv
// drrp_back: ring storage, end/read positions, publish table and read sequencer.
// Depends on drrp_pkg.
module drrp_back #(
    parameter int HALF_SIZE = drrp_pkg::HALF_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    input  drrp_pkg::op_t  op,
    output logic           op_pop,
    input  logic           res_full,
    output logic           res_push,
    output drrp_pkg::result_t res
);

    localparam int RING = 2 * HALF_SIZE;
    localparam int PW   = $clog2(RING);
    localparam int CW   = drrp_pkg::CNT_W;
    localparam logic [PW-1:0] HALF_P = PW'(HALF_SIZE);
    localparam logic [PW-1:0] LAST_P = PW'(RING - 1);
    localparam logic [PW:0]   RING_A = (PW + 1)'(RING);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RD_ADDR = 2'd1;
    localparam logic [1:0] ST_RD_DATA = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] rd_pos_reg, rd_pos_next;
    logic [PW-1:0] end_reg, end_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          short_reg, short_next;

    logic [drrp_pkg::BYTE_W-1:0] mem [RING];
    logic [RING-1:0]             wvld_reg;     // entry written since reset
    logic [drrp_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;
    logic                        mem_we;
    logic [PW-1:0]               op_pos;

    logic [PW-1:0] p_end, p_rd;
    logic          p_pub;
    logic [PW:0]   avail;
    logic [CW-1:0] avail_c, take;

    assign op_pos = op.pos[PW-1:0];

    // publish table
    always_comb
    begin
        p_end = end_reg;
        p_rd  = rd_pos_reg;
        p_pub = 1'b0;
        if (op_pos != end_reg)
        begin
            if (end_reg == '0)
            begin
                if (op_pos > HALF_P)
                begin
                    p_end = op_pos; p_rd = HALF_P; p_pub = 1'b1;
                end
                else if (rd_pos_reg == '0)
                begin
                    p_end = op_pos; p_pub = 1'b1;
                end
                else if (op_pos == HALF_P)
                begin
                    p_pub = (rd_pos_reg != HALF_P);
                    p_end = HALF_P; p_rd = '0;
                end
            end
            else if (end_reg < HALF_P)
            begin
                if (op_pos > HALF_P)
                begin
                    p_end = op_pos; p_rd = HALF_P; p_pub = 1'b1;
                end
                else if (op_pos >= end_reg)
                begin
                    p_end = op_pos; p_pub = 1'b1;
                end
            end
            else if (end_reg == HALF_P)
            begin
                if (op_pos < HALF_P && op_pos != '0)
                begin
                    p_end = op_pos; p_rd = '0; p_pub = 1'b1;
                end
                else if (rd_pos_reg == HALF_P)
                begin
                    p_end = op_pos; p_pub = 1'b1;
                end
                else if (op_pos == '0)
                begin
                    p_pub = (rd_pos_reg != '0);
                    p_end = '0; p_rd = HALF_P;
                end
            end
            else
            begin
                if (op_pos < end_reg && op_pos != '0)
                begin
                    if (op_pos <= HALF_P)
                    begin
                        p_end = op_pos; p_rd = '0; p_pub = 1'b1;
                    end
                end
                else
                begin
                    p_end = op_pos; p_pub = 1'b1;
                end
            end
        end
    end

    // bytes between read position and end, with wrap
    always_comb
    begin
        if (end_reg >= rd_pos_reg)
        begin
            avail = {1'b0, end_reg} - {1'b0, rd_pos_reg};
        end
        else
        begin
            avail = RING_A - {1'b0, rd_pos_reg} + {1'b0, end_reg};
        end
        avail_c = CW'(avail);
        take    = (avail_c < op.count) ? avail_c : op.count;
    end

    always_comb
    begin
        state_next  = state_reg;
        rd_pos_next = rd_pos_reg;
        end_next    = end_reg;
        pend_next   = pend_reg;
        remain_next = remain_reg;
        short_next  = short_reg;
        op_pop      = 1'b0;
        res_push    = 1'b0;
        mem_we      = 1'b0;
        res         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    case (op.kind)
                        drrp_pkg::CMD_WRITE:
                        begin
                            mem_we = 1'b1;
                            op_pop = 1'b1;
                        end
                        drrp_pkg::CMD_PUBLISH:
                        begin
                            op_pop      = 1'b1;
                            end_next    = p_end;
                            rd_pos_next = p_rd;
                            pend_next   = pend_reg || p_pub;
                        end
                        drrp_pkg::CMD_READ:
                        begin
                            if (op.count == '0)
                            begin
                                res.last = 1'b1;
                                res_push = !res_full;
                                op_pop   = !res_full;
                            end
                            else if (!pend_reg || take == '0)
                            begin
                                // nothing to hand out: flag drops
                                res.last   = 1'b1;
                                res.status = 1'b1;
                                res_push   = !res_full;
                                op_pop     = !res_full;
                                if (!res_full)
                                begin
                                    pend_next = 1'b0;
                                end
                            end
                            else
                            begin
                                op_pop      = 1'b1;
                                pend_next   = (avail_c > take);
                                remain_next = take;
                                short_next  = (take < op.count);
                                state_next  = ST_RD_ADDR;
                            end
                        end
                        default:
                        begin
                            op_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_ADDR:
            begin
                state_next = ST_RD_DATA;   // ring read in flight
            end
            ST_RD_DATA:
            begin
                res.data_byte  = rd_vld_reg ? rd_data_reg : '0;
                res.data_valid = 1'b1;
                res.last       = (remain_reg == CW'(1));
                res.status     = (remain_reg == CW'(1)) && short_reg;
                if (!res_full)
                begin
                    res_push    = 1'b1;
                    rd_pos_next = (rd_pos_reg == LAST_P) ? '0 : rd_pos_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    state_next  = (remain_reg == CW'(1)) ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_pos_reg <= '0;
            end_reg    <= '0;
            pend_reg   <= 1'b0;
            remain_reg <= '0;
            short_reg  <= 1'b0;
            wvld_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_pos_reg <= rd_pos_next;
            end_reg    <= end_next;
            pend_reg   <= pend_next;
            remain_reg <= remain_next;
            short_reg  <= short_next;
            if (mem_we)
            begin
                wvld_reg[op_pos] <= 1'b1;
            end
        end
    end

    // ring storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[op_pos] <= op.data;
        end
        rd_data_reg <= mem[rd_pos_reg];
        rd_vld_reg  <= wvld_reg[rd_pos_reg];
    end

endmodule

>>> rtl/core/dma_rx_ring_publish_and_read_core.sv
// dma_rx_ring_publish_and_read_core: top level of the DMA receive ring core.
// Depends on drrp_pkg, drrp_fifo, drrp_front and drrp_back.
//
// Receive ring of 2*HALF_SIZE bytes filled by a DMA engine in two halves. Input
// words are queued by the front (push/full) into a two-entry op queue; the back
// executes them in order. A byte write or a publish runs from idle; a publish
// advances the stored end, may move the read position to drop overflowed data, and
// sets the pending flag when something new was published. A read is set up in
// idle, then each delivered byte passes an address and a data state (the ring's
// read port is registered), stalling while the result queue is full; a read
// returning only a status word is answered from idle. Results sit in a two-entry
// result queue (empty/pop), so the front keeps taking words while a result waits.
// Writes to indexes, and publishes of ends, at or past the ring size are dropped,
// as is command code 3. Ring bytes read before they were ever written read as zero.
module dma_rx_ring_publish_and_read_core #(
    parameter int HALF_SIZE = drrp_pkg::HALF_SIZE_DEF   // 2..32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [drrp_pkg::CMD_W-1:0]  command,
    input  logic [drrp_pkg::POS_W-1:0]  write_index,
    input  logic [drrp_pkg::BYTE_W-1:0] write_byte,
    input  logic [drrp_pkg::POS_W-1:0]  new_end,
    input  logic [drrp_pkg::CNT_W-1:0]  read_count,
    output logic                        empty,
    input  logic                        pop,
    output logic [drrp_pkg::BYTE_W-1:0] data_byte,
    output logic                        data_valid,
    output logic                        last,
    output logic                        status
);

    logic              op_valid, op_pop;
    drrp_pkg::op_t     op;
    logic              res_full, res_push;
    drrp_pkg::result_t res, res_out;

    drrp_front #(
        .HALF_SIZE (HALF_SIZE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .write_index (write_index),
        .write_byte  (write_byte),
        .new_end     (new_end),
        .read_count  (read_count),
        .op_valid    (op_valid),
        .op          (op),
        .op_pop      (op_pop)
    );

    drrp_back #(
        .HALF_SIZE (HALF_SIZE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res      (res)
    );

    // result queue: decouples the read sequencer from the consumer
    drrp_fifo #(
        .DEPTH  (drrp_pkg::Q_DEPTH),
        .DATA_W ($bits(drrp_pkg::result_t))
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign data_byte  = res_out.data_byte;
    assign data_valid = res_out.data_valid;
    assign last       = res_out.last;
    assign status     = res_out.status;

    // back never drops a result or pulls from an empty op queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        op_pop |-> op_valid)
        else $error("op popped from empty queue");

    // short status only ever rides on the closing word
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> last)
        else $error("status set on a word that is not last");

    // a word without data carries a zero byte and closes the read
    a_nodata_word: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !data_valid) |-> (data_byte == '0 && last))
        else $error("empty word carries data or is not last");

endmodule

>>> tb/sv/ring_read_checker.sv
// ring_read_checker: tracks the receive ring, predicts every result word and
// compares it with what the core pops. Depends on drrp_pkg.
module ring_read_checker #(
    parameter int HALF_SIZE = drrp_pkg::HALF_SIZE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic [drrp_pkg::CMD_W-1:0]  command,
    input  logic [drrp_pkg::POS_W-1:0]  write_index,
    input  logic [drrp_pkg::BYTE_W-1:0] write_byte,
    input  logic [drrp_pkg::POS_W-1:0]  new_end,
    input  logic [drrp_pkg::CNT_W-1:0]  read_count,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [drrp_pkg::BYTE_W-1:0] data_byte,
    input  logic                        data_valid,
    input  logic                        last,
    input  logic                        status,
    output int                          mismatches,
    output int                          words_owed,
    output int                          words_checked
);

    localparam int POS_W  = drrp_pkg::POS_W;
    localparam int BYTE_W = drrp_pkg::BYTE_W;
    localparam int CNT_W  = drrp_pkg::CNT_W;

    localparam int RING = 2 * HALF_SIZE;
    localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF_SIZE);

    logic [BYTE_W-1:0]  ring_copy [0:63];
    logic [POS_W-1:0]   rd_pos;
    logic [POS_W-1:0]   end_pos;
    logic               pending;
    drrp_pkg::result_t  read_words_due [$];
    int                 miss_n;
    int                 checked_n;

    function automatic drrp_pkg::result_t make_word(input logic [BYTE_W-1:0] b,
                                                    input logic v,
                                                    input logic l, input logic s);
        drrp_pkg::result_t w;
        w.data_byte  = b;
        w.data_valid = v;
        w.last       = l;
        w.status     = s;
        return w;
    endfunction

    // publish: move the end, drop overflowed data per the half-buffer rules
    function automatic void advance_end(input logic [POS_W-1:0] t);
        logic fresh;
        fresh = 1'b0;
        if (t != end_pos)
        begin
            if (end_pos == '0)
            begin
                if (t > HALF_POS)
                begin
                    end_pos = t; rd_pos = HALF_POS; fresh = 1'b1;
                end
                else if (rd_pos == '0)
                begin
                    end_pos = t; fresh = 1'b1;
                end
                else if (t == HALF_POS)
                begin
                    fresh = (rd_pos != HALF_POS);
                    end_pos = HALF_POS; rd_pos = '0;
                end
            end
            else if (end_pos < HALF_POS)
            begin
                if (t > HALF_POS)
                begin
                    end_pos = t; rd_pos = HALF_POS; fresh = 1'b1;
                end
                else if (t >= end_pos)
                begin
                    end_pos = t; fresh = 1'b1;
                end
            end
            else if (end_pos == HALF_POS)
            begin
                if (t < HALF_POS && t != '0)
                begin
                    end_pos = t; rd_pos = '0; fresh = 1'b1;
                end
                else if (rd_pos == HALF_POS)
                begin
                    end_pos = t; fresh = 1'b1;
                end
                else if (t == '0)
                begin
                    fresh = (rd_pos != '0);
                    end_pos = '0; rd_pos = HALF_POS;
                end
            end
            else
            begin
                if (t < end_pos && t != '0)
                begin
                    if (t <= HALF_POS)
                    begin
                        end_pos = t; rd_pos = '0; fresh = 1'b1;
                    end
                end
                else
                begin
                    end_pos = t; fresh = 1'b1;
                end
            end
        end
        if (fresh)
            pending = 1'b1;
    endfunction

    function automatic void serve_read(input logic [CNT_W-1:0] n);
        int avail;
        int count;
        if (n == '0)
            read_words_due.push_back(make_word('0, 1'b0, 1'b1, 1'b0));
        else if (!pending)
            read_words_due.push_back(make_word('0, 1'b0, 1'b1, 1'b1));
        else
        begin
            if (end_pos >= rd_pos)
                avail = int'(end_pos) - int'(rd_pos);
            else
                avail = RING - int'(rd_pos) + int'(end_pos);
            count = (avail < int'(n)) ? avail : int'(n);
            pending = (avail > count);
            if (count == 0)
                read_words_due.push_back(make_word('0, 1'b0, 1'b1, 1'b1));
            for (int k = 0; k < count; k++)
            begin
                read_words_due.push_back(make_word(ring_copy[rd_pos], 1'b1, k + 1 == count,
                                                   (k + 1 == count) && count < int'(n)));
                rd_pos = (int'(rd_pos) + 1 >= RING) ? '0 : rd_pos + 1'b1;
            end
        end
    endfunction

    function automatic void flag_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            miss_n++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        drrp_pkg::result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 64; i++)
                ring_copy[i] = '0;
            rd_pos    = '0;
            end_pos   = '0;
            pending   = 1'b0;
            miss_n    = 0;
            checked_n = 0;
            read_words_due.delete();
            mismatches    <= 0;
            words_owed    <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (read_words_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %s %0h %0b %0b %0b",
                             $time, "byte/valid/last/status", data_byte, data_valid,
                             last, status);
                    miss_n++;
                end
                else
                begin
                    want = read_words_due.pop_front();
                    checked_n++;
                    flag_field("data_byte", int'(want.data_byte), int'(data_byte));
                    flag_field("data_valid", int'(want.data_valid), int'(data_valid));
                    flag_field("last", int'(want.last), int'(last));
                    flag_field("status", int'(want.status), int'(status));
                end
            end
            if (push && !full)
            begin
                case (command)
                    drrp_pkg::CMD_WRITE:
                        if (int'(write_index) < RING)
                            ring_copy[write_index] = write_byte;
                    drrp_pkg::CMD_PUBLISH:
                        if (int'(new_end) < RING)
                            advance_end(new_end);
                    drrp_pkg::CMD_READ:
                        serve_read(read_count);
                    default: ;
                endcase
            end
            mismatches    <= miss_n;
            words_owed    <= read_words_due.size();
            words_checked <= checked_n;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// testbench: stimulus and verdict for the DMA receive ring core.
// Depends on drrp_pkg, dma_rx_ring_publish_and_read_core and ring_read_checker.
module testbench;

    localparam int CMD_W  = drrp_pkg::CMD_W;
    localparam int POS_W  = drrp_pkg::POS_W;
    localparam int BYTE_W = drrp_pkg::BYTE_W;
    localparam int CNT_W  = drrp_pkg::CNT_W;

    // command code with no meaning; the core drops it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int WORDS_WANTED = 450;
    localparam int CYCLE_LIMIT  = 400000;   // worst case is far below this
    localparam int HOLD_CYCLES  = 400;      // long receiver stall
    localparam int TAIL_CYCLES  = 40;       // writes/publishes can still be in flight

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  write_index;
    logic [BYTE_W-1:0] write_byte;
    logic [POS_W-1:0]  new_end;
    logic [CNT_W-1:0]  read_count;
    logic              empty;
    logic              pop;
    logic [BYTE_W-1:0] data_byte;
    logic              data_valid;
    logic              last;
    logic              status;

    int mismatches;
    int words_owed;
    int words_checked;

    // run bookkeeping; words_sent is also read by the receiver process
    int words_sent;
    int reads_sent;
    int cycles;

    dma_rx_ring_publish_and_read_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .write_index (write_index),
        .write_byte  (write_byte),
        .new_end     (new_end),
        .read_count  (read_count),
        .empty       (empty),
        .pop         (pop),
        .data_byte   (data_byte),
        .data_valid  (data_valid),
        .last        (last),
        .status      (status)
    );

    ring_read_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .command       (command),
        .write_index   (write_index),
        .write_byte    (write_byte),
        .new_end       (new_end),
        .read_count    (read_count),
        .empty         (empty),
        .pop           (pop),
        .data_byte     (data_byte),
        .data_valid    (data_valid),
        .last          (last),
        .status        (status),
        .mismatches    (mismatches),
        .words_owed    (words_owed),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still owed", cycles, words_owed);
        $display("*** FAILED ***");
        $finish;
    end

    // Both sides run without gaps in this window of the word count.
    function automatic bit calm_window();
        return words_sent >= 100 && words_sent < 160;
    endfunction

    // Receiver: pops about 90% of cycles. Once, mid run, it stalls for a long
    // stretch while the sender keeps pushing, so both queues fill and full rises.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        pop <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && words_sent >= 200)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else
                pop <= calm_window() || ($urandom_range(0, 99) >= 10);
        end
    end

    // Offer one word and hold it until the core takes it. Leaves push high
    // so back-to-back words need no bubble.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] idx,
                             input logic [BYTE_W-1:0] b, input logic [POS_W-1:0] ne,
                             input logic [CNT_W-1:0] cnt);
        if (!calm_window() && $urandom_range(0, 99) < 10)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push        <= 1'b1;
        command     <= cmd;
        write_index <= idx;
        write_byte  <= b;
        new_end     <= ne;
        read_count  <= cnt;
        do @(posedge clk); while (full);
        if (cmd != CMD_UNUSED)
            words_sent++;
        if (cmd == drrp_pkg::CMD_READ)
            reads_sent++;
    endtask

    // Unused fields of a word carry random junk; the core must ignore them.
    task automatic send_write(input logic [POS_W-1:0] idx, input logic [BYTE_W-1:0] b);
        send_word(drrp_pkg::CMD_WRITE, idx, b, POS_W'($urandom),
                  CNT_W'($urandom_range(0, 64)));
    endtask

    task automatic send_publish(input logic [POS_W-1:0] ne);
        send_word(drrp_pkg::CMD_PUBLISH, POS_W'($urandom), BYTE_W'($urandom), ne,
                  CNT_W'($urandom_range(0, 64)));
    endtask

    task automatic send_read(input logic [CNT_W-1:0] cnt);
        send_word(drrp_pkg::CMD_READ, POS_W'($urandom), BYTE_W'($urandom),
                  POS_W'($urandom), cnt);
    endtask

    // Stop offering words until every owed result word has been popped.
    task automatic drain_results();
        push <= 1'b0;
        do @(posedge clk); while (words_owed != 0);
    endtask

    // A DMA burst: bytes land after the fill point, then the new end is
    // published and usually a read follows. Now and then the publish is
    // skipped to leave a broken sequence behind.
    task automatic dma_burst(inout int fill_pos);
        int k;
        int reach;
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < k; i++)
            send_write(POS_W'((fill_pos + i) % 64), BYTE_W'($urandom));
        if ($urandom_range(0, 9) != 0)
        begin
            fill_pos = (fill_pos + k) % 64;
            send_publish(POS_W'(fill_pos));
        end
        if ($urandom_range(0, 9) < 6)
        begin
            reach = (k + 2 > 64) ? 64 : k + 2;
            if ($urandom_range(0, 9) == 0)
                send_read(CNT_W'($urandom_range(0, 64)));
            else
                send_read(CNT_W'($urandom_range(1, reach)));
        end
    endtask

    initial
    begin : stimulus
        int fill_pos;
        int pick;
        bit paused;
        rst_n       <= 1'b0;
        push        <= 1'b0;
        command     <= drrp_pkg::CMD_WRITE;
        write_index <= '0;
        write_byte  <= '0;
        new_end     <= '0;
        read_count  <= '0;
        words_sent  = 0;
        reads_sent  = 0;
        fill_pos    = 0;
        paused      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: walks the publish table from reset state.
        send_read(7'd5);                    // nothing published yet -> short status
        send_read(7'd0);                    // zero-length read
        send_write(6'd0, 8'hA5);
        send_write(6'd63, 8'hFF);
        send_write(6'd1, 8'h00);
        send_word(CMD_UNUSED, 6'd63, 8'hFF, 6'd63, 7'd64);   // unknown command, dropped
        send_publish(6'd0);                 // same end, no change
        send_publish(6'd2);                 // low half grows from empty
        send_read(7'd64);                   // two bytes, short
        send_read(7'd3);                    // flag already cleared
        send_publish(6'd40);                // low half overflow into high
        send_read(7'd8);                    // exact fit, status clean
        send_publish(6'd32);                // wrap back from high half
        send_read(7'd1);
        send_publish(6'd0);                 // end at half, DMA wrapped to zero
        send_publish(6'd63);                // end at zero jumps past half
        send_publish(6'd50);                // backward step in high half, invalid
        send_read(7'd63);
        send_write(6'd63, 8'h5A);
        send_publish(6'd10);                // wrap from high end into low half
        send_read(7'd64);
        send_publish(6'd32);
        send_read(7'd0);                    // zero-length while data pending
        send_read(7'd64);

        fill_pos = 32;
        while (words_sent < WORDS_WANTED)
        begin
            if (!paused && words_sent >= 300)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                dma_burst(fill_pos);
            else if (pick < 82)
                send_read(CNT_W'($urandom_range(0, 64)));
            else if (pick < 92)
                send_publish(POS_W'($urandom));
            else
                send_word(CMD_W'($urandom_range(0, 3)), POS_W'($urandom),
                          BYTE_W'($urandom), POS_W'($urandom),
                          CNT_W'($urandom_range(0, 64)));
        end

        // Wait out every owed word, then give stray results time to show up.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run: %0d words sent, %0d of them reads, over %0d cycles",
                 words_sent, reads_sent, cycles);
        $display("Run: %0d result words compared, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
